### rtl/bsrc_pkg.sv
// ----------------------------------------------------------------------------
// bsrc_pkg
// Shared constants and result codes for the banker's safe request checker.
// ----------------------------------------------------------------------------
package bsrc_pkg;

	localparam int DEF_MAX_PROCS   = 8;
	localparam int DEF_MAX_RES     = 4;
	localparam int DEF_AMOUNT_BITS = 8;

	localparam logic [1:0] FN_LOAD_AVAIL = 2'd0;
	localparam logic [1:0] FN_LOAD_MAX   = 2'd1;
	localparam logic [1:0] FN_LOAD_ALLOC = 2'd2;
	localparam logic [1:0] FN_REQUEST    = 2'd3;

	localparam logic [2:0] STS_LOADED     = 3'd0;
	localparam logic [2:0] STS_GRANTED    = 3'd1;
	localparam logic [2:0] STS_OVER_NEED  = 3'd2;
	localparam logic [2:0] STS_OVER_AVAIL = 3'd3;
	localparam logic [2:0] STS_UNSAFE     = 3'd4;
	localparam logic [2:0] STS_BAD_INDEX  = 3'd5;

	localparam logic CFG_PROC_COUNT = 1'b0;
	localparam logic CFG_RES_COUNT  = 1'b1;

endpackage

### rtl/bankers_safe_request_check_core.sv
// ----------------------------------------------------------------------------
// bankers_safe_request_check_core
// Banker's deadlock-avoidance engine: table loads, request checks, safety scan.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// item      | in        | item_valid/item_stall| func process resource value req_0..3
// result    | out       | result_valid/stall   | status seq_process last
// cfg       | in        | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// Loads reach the output register through S_RESP (row loads via S_LDWR first),
// rejections through S_RESP (request rejections via S_REQCHK first). A request
// scan streams one process row per cycle from the row memory: up to proc_count
// passes of proc_count rows, then one result per process.
// Reset clears control state and row valid bits; unwritten rows read as zero.
// Result stall holds the output register; items stall while one is in work.
module bankers_safe_request_check_core #(
	parameter int MAX_PROCS   = bsrc_pkg::DEF_MAX_PROCS,
	parameter int MAX_RES     = bsrc_pkg::DEF_MAX_RES,
	parameter int AMOUNT_BITS = bsrc_pkg::DEF_AMOUNT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] func,
	input  logic [2:0] process,
	input  logic [1:0] resource,
	input  logic [7:0] value,
	input  logic [7:0] req_0,
	input  logic [7:0] req_1,
	input  logic [7:0] req_2,
	input  logic [7:0] req_3,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] status,
	output logic [2:0] seq_process,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);
	import bsrc_pkg::*;

	localparam int AB   = AMOUNT_BITS;
	localparam int PW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int NPW  = $clog2(MAX_PROCS + 1);
	localparam int CW   = (NPW > 4) ? NPW : 4;
	localparam int WW   = AB + $clog2(MAX_PROCS + 1) + 1;
	localparam int ROWW = 2 * MAX_RES * AB;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LDWR   = 3'd1;
	localparam logic [2:0] S_REQCHK = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0] state_q;
	logic [3:0] pc_q;
	logic [2:0] rc_q;
	logic [CW-1:0] np;
	logic [2:0] nr;

	logic [AB-1:0] avail_q [MAX_RES];
	logic [ROWW-1:0] mem [MAX_PROCS];
	logic [MAX_PROCS-1:0] row_vld_q;
	logic [ROWW-1:0] rdata_q;
	logic rvld_q;
	logic [PW-1:0] rd_addr;
	logic mem_we;
	logic [PW-1:0] mem_wa;
	logic [ROWW-1:0] mem_wd;

	logic [1:0] func_q;
	logic [PW-1:0] proc_q;
	logic [RW-1:0] res_q;
	logic [AB-1:0] val_q;
	logic [AB-1:0] req_q [MAX_RES];
	logic [ROWW-1:0] prow_q;
	logic [2:0] sts_q;

	logic [WW-1:0] work_q [MAX_RES];
	logic [MAX_PROCS-1:0] done_q;
	logic [PW-1:0] order_q [MAX_PROCS];
	logic [CW-1:0] count_q;
	logic [PW-1:0] cmp_q;
	logic [PW-1:0] cmp_nxt;
	logic found_q;
	logic [CW-1:0] emit_q;

	logic out_v_q;
	logic [2:0] out_sts_q;
	logic [2:0] out_seq_q;
	logic out_last_q;
	logic ofree;
	logic accept;

	logic [ROWW-1:0] row;
	logic [AB-1:0] row_max [MAX_RES];
	logic [AB-1:0] row_alloc [MAX_RES];
	logic [AB-1:0] alloc_eff [MAX_RES];
	logic [AB:0] need [MAX_RES];
	logic fits;
	logic over_need;
	logic over_avail;
	logic [AB-1:0] req_in [4];

	assign np = (pc_q == 4'd0) ? CW'(1) :
		((CW'(pc_q) > CW'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(pc_q));
	assign nr = (rc_q == 3'd0) ? 3'd1 :
		((rc_q > 3'(MAX_RES)) ? 3'(MAX_RES) : rc_q);

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign ofree        = !out_v_q || !result_stall;
	assign result_valid = out_v_q;
	assign status       = out_sts_q;
	assign seq_process  = out_seq_q;
	assign last         = out_last_q;

	assign req_in[0] = AB'(req_0);
	assign req_in[1] = AB'(req_1);
	assign req_in[2] = AB'(req_2);
	assign req_in[3] = AB'(req_3);

	assign cmp_nxt = (CW'(cmp_q) == np - CW'(1)) ? '0 : cmp_q + PW'(1);

	always_comb begin
		unique case (state_q)
			S_IDLE:   rd_addr = PW'(process);
			S_REQCHK: rd_addr = '0;
			default:  rd_addr = cmp_nxt;
		endcase
	end

	always_comb begin
		row = rvld_q ? rdata_q : '0;
		fits = 1'b1;
		over_need = 1'b0;
		over_avail = 1'b0;
		for (int r = 0; r < MAX_RES; r++) begin
			row_alloc[r] = row[r*AB +: AB];
			row_max[r]   = row[(MAX_RES + r)*AB +: AB];
			alloc_eff[r] = (state_q == S_SCAN && cmp_q == proc_q) ?
				row_alloc[r] + req_q[r] : row_alloc[r];
			need[r] = {1'b0, row_max[r]} - {1'b0, alloc_eff[r]};
			if (3'(r) < nr) begin
				if ($signed({{(WW-AB){need[r][AB]}}, need[r]}) > $signed({1'b0, work_q[r]}))
					fits = 1'b0;
				if ($signed({1'b0, req_q[r]}) > $signed(need[r]))
					over_need = 1'b1;
				if (req_q[r] > avail_q[r])
					over_avail = 1'b1;
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = proc_q;
		mem_wd = row;
		if (state_q == S_LDWR) begin
			mem_we = 1'b1;
			for (int r = 0; r < MAX_RES; r++) begin
				if (RW'(r) == res_q) begin
					if (func_q == FN_LOAD_MAX)
						mem_wd[(MAX_RES + r)*AB +: AB] = val_q;
					else
						mem_wd[r*AB +: AB] = val_q;
				end
			end
		end else if (state_q == S_COMMIT) begin
			mem_we = 1'b1;
			mem_wd = prow_q;
			for (int r = 0; r < MAX_RES; r++) begin
				if (3'(r) < nr)
					mem_wd[r*AB +: AB] = prow_q[r*AB +: AB] + req_q[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			rvld_q <= row_vld_q[rd_addr];
			if (mem_we)
				row_vld_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 4'd8;
			rc_q <= 3'd4;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PROC_COUNT)
				pc_q <= cfg_data;
			else
				rc_q <= cfg_data[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			proc_q <= PW'(process);
			res_q  <= RW'(resource);
			val_q  <= AB'(value);
			for (int r = 0; r < MAX_RES; r++)
				req_q[r] <= req_in[r];
		end
		if (state_q == S_REQCHK) begin
			prow_q <= row;
			for (int r = 0; r < MAX_RES; r++)
				work_q[r] <= WW'(avail_q[r]) - WW'(req_q[r]);
		end
		if (state_q == S_SCAN && !done_q[cmp_q] && fits) begin
			for (int r = 0; r < MAX_RES; r++)
				work_q[r] <= work_q[r] + WW'(alloc_eff[r]);
			order_q[count_q[PW-1:0]] <= cmp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sts_q      <= STS_LOADED;
			done_q     <= '0;
			count_q    <= '0;
			cmp_q      <= '0;
			found_q    <= 1'b0;
			emit_q     <= '0;
			out_v_q    <= 1'b0;
			out_sts_q  <= STS_LOADED;
			out_seq_q  <= '0;
			out_last_q <= 1'b0;
			for (int r = 0; r < MAX_RES; r++)
				avail_q[r] <= '0;
		end else begin
			if (out_v_q && !result_stall && state_q != S_EMIT && state_q != S_RESP)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FN_LOAD_AVAIL) begin
							state_q <= S_RESP;
							if (3'(resource) >= nr) begin
								sts_q <= STS_BAD_INDEX;
							end else begin
								sts_q <= STS_LOADED;
								avail_q[RW'(resource)] <= AB'(value);
							end
						end else if (CW'(process) >= np ||
								(func != FN_REQUEST && 3'(resource) >= nr)) begin
							sts_q   <= STS_BAD_INDEX;
							state_q <= S_RESP;
						end else if (func == FN_REQUEST) begin
							state_q <= S_REQCHK;
						end else begin
							state_q <= S_LDWR;
						end
					end
				end
				S_LDWR: begin
					sts_q   <= STS_LOADED;
					state_q <= S_RESP;
				end
				S_REQCHK: begin
					if (over_need) begin
						sts_q   <= STS_OVER_NEED;
						state_q <= S_RESP;
					end else if (over_avail) begin
						sts_q   <= STS_OVER_AVAIL;
						state_q <= S_RESP;
					end else begin
						done_q  <= '0;
						count_q <= '0;
						cmp_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_q <= cmp_nxt;
					if (!done_q[cmp_q] && fits) begin
						done_q[cmp_q] <= 1'b1;
						count_q <= count_q + CW'(1);
						found_q <= (CW'(cmp_q) != np - CW'(1));
						if (count_q + CW'(1) == np)
							state_q <= S_COMMIT;
					end else if (CW'(cmp_q) == np - CW'(1)) begin
						found_q <= 1'b0;
						if (!found_q) begin
							sts_q   <= STS_UNSAFE;
							state_q <= S_RESP;
						end
					end
				end
				S_COMMIT: begin
					for (int r = 0; r < MAX_RES; r++) begin
						if (3'(r) < nr)
							avail_q[r] <= avail_q[r] - req_q[r];
					end
					emit_q  <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (ofree) begin
						out_v_q    <= 1'b1;
						out_sts_q  <= STS_GRANTED;
						out_seq_q  <= 3'(order_q[emit_q[PW-1:0]]);
						out_last_q <= (emit_q == np - CW'(1));
						emit_q     <= emit_q + CW'(1);
						if (emit_q == np - CW'(1))
							state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (ofree) begin
						out_v_q    <= 1'b1;
						out_sts_q  <= sts_q;
						out_seq_q  <= '0;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/bsrc_checker.sv
// ----------------------------------------------------------------------------
// bsrc_checker
// Port-level checks for the banker's safe request checker.
// ----------------------------------------------------------------------------
module bsrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [2:0] status,
	input logic [2:0] seq_process,
	input logic       last
);
	import bsrc_pkg::*;

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STS_GRANTED |-> last)
		else $error("non-grant result without last");

	a_single_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STS_GRANTED |-> seq_process == 3'd0)
		else $error("non-grant result with nonzero process");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while previous transaction in work");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind bankers_safe_request_check_core bsrc_checker u_bsrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.seq_process  (seq_process),
	.last         (last)
);
